// File: hdl/assert_macros.svh
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: hdl/agm_pkg.sv
`timescale 1ns / 1ps
package agm_pkg;

	localparam int AGM_MAX_SLOTS   = 64;
	localparam int AGM_WEIGHT_BITS = 16;

	localparam logic [2:0] REQ_ADD_VERTEX    = 3'd0;
	localparam logic [2:0] REQ_SET_EDGE      = 3'd1;
	localparam logic [2:0] REQ_CLEAR_EDGE    = 3'd2;
	localparam logic [2:0] REQ_REMOVE_VERTEX = 3'd3;
	localparam logic [2:0] REQ_READ_EDGE     = 3'd4;

	localparam logic CFG_MAX_VERTICES = 1'b0;
	localparam logic CFG_GRAPH_TYPE   = 1'b1;

	localparam logic GRAPH_UNDIRECTED = 1'b0;

	localparam logic ST_ACCEPTED = 1'b0;
	localparam logic ST_REJECTED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MIRROR,
		ST_RDATA,
		ST_CLEAR
	} agm_state_t;

	typedef struct packed {
		logic [6:0] max_vertices;
		logic       graph_type;
	} agm_cfg_t;

	typedef struct packed {
		logic        status;
		logic [15:0] read_weight;
		logic [6:0]  vertex_count;
	} agm_result_t;

endpackage

// File: hdl/agm_ram.sv
`timescale 1ns / 1ps
module agm_ram #(
	parameter int AW = 12,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/agm_ctrl.sv
`timescale 1ns / 1ps
module agm_ctrl #(
	parameter int MAX_SLOTS   = 64,
	parameter int WEIGHT_BITS = 16,
	parameter int AW          = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  agm_pkg::agm_cfg_t       cfg,
	input  logic                    start,
	input  logic [2:0]              req_type,
	input  logic [5:0]              first_vertex,
	input  logic [5:0]              second_vertex,
	input  logic signed [15:0]      edge_weight,
	output logic                    busy,
	output logic                    done,
	output agm_pkg::agm_result_t    res,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_addr,
	output logic [WEIGHT_BITS-1:0]  mem_wdata,
	input  logic [WEIGHT_BITS-1:0]  mem_rdata
);

	import agm_pkg::*;

	localparam int SW    = AW / 2;
	localparam int CW    = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W = (CW > 7) ? CW : 7;

	agm_state_t               state_q, state_d;
	logic [MAX_SLOTS-1:0]     present_q, present_d;
	logic [CW-1:0]            count_q, count_d;
	logic                     done_q, done_d;
	agm_result_t              res_q, res_d;
	logic [SW-1:0]            vtx_q, oth_q;
	logic [WEIGHT_BITS-1:0]   wdata_q;
	logic [SW:0]              walk_q, walk_d;

	logic [CMP_W-1:0]         lim;
	logic [SW-1:0]            a_idx, b_idx;
	logic                     a_in, b_in, a_ok, b_ok;
	logic                     accept;
	logic [WEIGHT_BITS-1:0]   wr_w;

	always_comb begin
		lim = (CMP_W'(cfg.max_vertices) > CMP_W'(MAX_SLOTS))
			? CMP_W'(MAX_SLOTS) : CMP_W'(cfg.max_vertices);
		a_in  = CMP_W'(first_vertex) < lim;
		b_in  = CMP_W'(second_vertex) < lim;
		a_idx = SW'(CMP_W'(first_vertex));
		b_idx = SW'(CMP_W'(second_vertex));
		a_ok  = a_in && present_q[a_idx];
		b_ok  = b_in && present_q[b_idx];
		wr_w  = (req_type == REQ_SET_EDGE) ? WEIGHT_BITS'(32'(edge_weight)) : '0;
	end

	assign accept = start && (state_q == ST_IDLE);

	// A slot's row and column are swept to zero when the vertex is added, so
	// every entry between two present vertices is zero until written.
	always_comb begin
		state_d   = state_q;
		present_d = present_q;
		count_d   = count_q;
		done_d    = 1'b0;
		res_d     = res_q;
		walk_d    = walk_q;
		mem_we    = 1'b0;
		mem_addr  = {a_idx, b_idx};
		mem_wdata = wr_w;
		unique case (state_q)
			ST_IDLE: begin
				walk_d = '0;
				if (start) begin
					done_d            = 1'b1;
					res_d.status      = ST_REJECTED;
					res_d.read_weight = '0;
					case (req_type) inside
						REQ_ADD_VERTEX: begin
							if (a_in) begin
								res_d.status = ST_ACCEPTED;
								if (!present_q[a_idx]) begin
									present_d[a_idx] = 1'b1;
									count_d          = count_q + 1'b1;
									state_d          = ST_CLEAR;
								end
							end
						end
						REQ_SET_EDGE, REQ_CLEAR_EDGE: begin
							if (a_ok && b_ok) begin
								res_d.status = ST_ACCEPTED;
								mem_we       = 1'b1;
								if (cfg.graph_type == GRAPH_UNDIRECTED) begin
									state_d = ST_MIRROR;
								end
							end
						end
						REQ_REMOVE_VERTEX: begin
							if (a_ok) begin
								res_d.status     = ST_ACCEPTED;
								present_d[a_idx] = 1'b0;
								if (count_q != '0) begin
									count_d = count_q - 1'b1;
								end
							end
						end
						REQ_READ_EDGE: begin
							if (a_ok && b_ok) begin
								done_d  = 1'b0;
								state_d = ST_RDATA;
							end
						end
						default: begin
						end
					endcase
					res_d.vertex_count = 7'(count_d);
				end
			end
			ST_MIRROR: begin
				mem_we    = 1'b1;
				mem_addr  = {oth_q, vtx_q};
				mem_wdata = wdata_q;
				state_d   = ST_IDLE;
			end
			ST_RDATA: begin
				done_d            = 1'b1;
				res_d.status      = ST_ACCEPTED;
				res_d.read_weight = 16'(32'($signed(mem_rdata)));
				state_d           = ST_IDLE;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				mem_addr  = walk_q[0] ? {walk_q[SW:1], vtx_q} : {vtx_q, walk_q[SW:1]};
				walk_d    = walk_q + 1'b1;
				if (walk_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			present_q <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
			walk_q    <= '0;
		end else begin
			state_q   <= state_d;
			present_q <= present_d;
			count_q   <= count_d;
			done_q    <= done_d;
			walk_q    <= walk_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			vtx_q   <= a_idx;
			oth_q   <= b_idx;
			wdata_q <= wr_w;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

// File: hdl/adjacency_matrix_graph_store.sv
`timescale 1ns / 1ps
// Channel    Handshake                  Payload
// request    start / busy               req_type, first_vertex, second_vertex, edge_weight
// result     done (one-cycle strobe)    status, read_weight, vertex_count
// config     cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One request per idle cycle; the result strobes the cycle after acceptance
// (for an accepted read edge, after the RDATA state). busy is held through
// the MIRROR state for a mirrored edge write, the RDATA state for an
// accepted read edge, and the CLEAR state after adding a new vertex while
// the single RAM port sweeps its row and column to zero. No clearing pass
// after reset. The receiver cannot stall: the result is valid only while
// done is high.
`include "assert_macros.svh"
module adjacency_matrix_graph_store #(
	parameter int MAX_SLOTS   = agm_pkg::AGM_MAX_SLOTS,
	parameter int WEIGHT_BITS = agm_pkg::AGM_WEIGHT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic [5:0]         first_vertex,
	input  logic [5:0]         second_vertex,
	input  logic signed [15:0] edge_weight,
	output logic               done,
	output logic               status,
	output logic signed [15:0] read_weight,
	output logic [6:0]         vertex_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [6:0]         cfg_data
);

	import agm_pkg::*;

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int AW = 2 * SW;

	agm_cfg_t               cfg_q;
	agm_result_t            res;
	logic                   mem_we;
	logic [AW-1:0]          mem_addr;
	logic [WEIGHT_BITS-1:0] mem_wdata;
	logic [WEIGHT_BITS-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_vertices <= 7'd64;
			cfg_q.graph_type   <= GRAPH_UNDIRECTED;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_VERTICES: cfg_q.max_vertices <= cfg_data;
				CFG_GRAPH_TYPE:   cfg_q.graph_type   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	agm_ctrl #(
		.MAX_SLOTS   (MAX_SLOTS),
		.WEIGHT_BITS (WEIGHT_BITS),
		.AW          (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.start         (start),
		.req_type      (req_type),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.edge_weight   (edge_weight),
		.busy          (busy),
		.done          (done),
		.res           (res),
		.mem_we        (mem_we),
		.mem_addr      (mem_addr),
		.mem_wdata     (mem_wdata),
		.mem_rdata     (mem_rdata)
	);

	agm_ram #(
		.AW (AW),
		.DW (WEIGHT_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign status       = res.status;
	assign read_weight  = res.read_weight;
	assign vertex_count = res.vertex_count;

	`ASSERT_CLK(a_accept_progress, clk, arst_n, (start && !busy) |=> (done || busy), "no progress")
	`ASSERT_CLK(a_rej_zero, clk, arst_n, (done && status) |-> (read_weight == '0), "weight on reject")
	`ASSERT_CLK(a_busy_from_start, clk, arst_n, $rose(busy) |-> $past(start), "busy without start")

endmodule
